FILE: design/dtcf_pkg.sv
// shared types, constants and format decoding for the double to custom float converter
`default_nettype none

package dtcf_pkg;

   localparam int LZ_W = 6;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_TOTAL_BITS = 1'b0,
      CSR_EXP_BITS   = 1'b1
   } csr_index_type;

   localparam logic [6:0] TOTAL_BITS_RESET = 7'd32;
   localparam logic [3:0] EXP_BITS_RESET   = 4'd8;

   // decoded target format
   typedef struct packed {
      logic        valid;
      logic [5:0]  sign_pos;
      logic [5:0]  frac_bits;
      logic [10:0] exp_max;
      logic [9:0]  bias;
   } fmt_type;

   function automatic fmt_type make_fmt(input logic [6:0] total_bits, input logic [3:0] exp_bits);
      fmt_type     fmt;
      logic [7:0]  t_ext;
      logic [7:0]  e_ext;
      logic [11:0] exp_max_w;
      logic [10:0] bias_w;
      t_ext         = {1'b0, total_bits};
      e_ext         = {4'b0, exp_bits};
      fmt.valid     = (t_ext >= 8'd3) && (t_ext <= 8'd64) && (e_ext >= 8'd2)
                      && (e_ext <= 8'd11) && ((e_ext + 8'd2) <= t_ext);
      fmt.sign_pos  = 6'(total_bits - 7'd1);
      fmt.frac_bits = 6'(total_bits - {3'b0, exp_bits} - 7'd1);
      exp_max_w     = (12'd1 << exp_bits) - 12'd1;
      bias_w        = (11'd1 << (exp_bits - 4'd1)) - 11'd1;
      fmt.exp_max   = exp_max_w[10:0];
      fmt.bias      = bias_w[9:0];
      return fmt;
   endfunction

endpackage

`default_nettype wire

FILE: design/dtcf_lzc.sv
// leading zero count of the double fraction field, used to normalise subnormal inputs
`default_nettype none

module dtcf_lzc (
   input  logic [51:0]                 frac,
   output logic [dtcf_pkg::LZ_W-1:0]   lead_zeros
);
   import dtcf_pkg::*;

   logic [55:0] padded;
   logic [7:0]  grp;
   logic [6:0]  grp_any;
   logic [2:0]  grp_lz [7];

   // seven byte groups, then pick the first non-empty one
   always_comb begin
      padded = {frac, 4'b0};
      for (int g = 0; g < 7; g++) begin
         grp        = padded[55-8*g -: 8];
         grp_any[g] = |grp;
         grp_lz[g]  = '0;
         for (int j = 0; j < 8; j++) begin
            if (grp[j]) begin
               grp_lz[g] = 3'(7 - j);
            end
         end
      end
      lead_zeros = '0;
      for (int g = 6; g >= 0; g--) begin
         if (grp_any[g]) begin
            lead_zeros = {3'(g), grp_lz[g]};
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/dtcf_convert.sv
// re-biasing, rounding and packing of one double into the configured format
`default_nettype none

module dtcf_convert (
   input  logic [63:0]                 double_bits,
   input  logic [dtcf_pkg::LZ_W-1:0]   lead_zeros,
   input  dtcf_pkg::fmt_type           fmt,
   output logic [63:0]                 packed_value
);
   import dtcf_pkg::*;

   // drop sh bits and add the first dropped bit
   function automatic logic [63:0] round_half_up(input logic [63:0] v, input logic [5:0] sh);
      logic [5:0] gpos;
      gpos = sh - 6'd1;
      return (v >> sh) + {63'b0, v[gpos]};
   endfunction

   logic               sgn;
   logic [10:0]        e11;
   logic [51:0]        frac;
   logic [63:0]        sign_word;
   logic [63:0]        inf_word;
   logic [52:0]        mant;
   logic signed [12:0] ue;
   logic signed [12:0] te;
   logic signed [12:0] sub_sh;
   logic signed [12:0] neg_sh;
   logic [63:0]        g_norm;
   logic [63:0]        mag_norm;
   logic [63:0]        g_sub;

   always_comb begin
      sgn       = double_bits[63];
      e11       = double_bits[62:52];
      frac      = double_bits[51:0];
      sign_word = {63'b0, sgn} << fmt.sign_pos;
      inf_word  = sign_word | ({53'b0, fmt.exp_max} << fmt.frac_bits);

      if (e11 == '0) begin
         mant = 53'({frac, 1'b0} << lead_zeros);
         ue   = -13'sd1023 - $signed({7'b0, lead_zeros});
      end else begin
         mant = {1'b1, frac};
         ue   = $signed({2'b0, e11}) - 13'sd1023;
      end
      te = ue + $signed({3'b0, fmt.bias});

      // normal range: fraction widened or rounded, carry runs into the exponent
      if (fmt.frac_bits >= 6'd52) begin
         g_norm = {12'b0, mant[51:0]} << (fmt.frac_bits - 6'd52);
      end else begin
         g_norm = round_half_up({12'b0, mant[51:0]}, 6'd52 - fmt.frac_bits);
      end
      mag_norm = ({53'b0, te[10:0]} << fmt.frac_bits) + g_norm;

      // subnormal range: scale to units of the smallest subnormal
      sub_sh = 13'sd53 - $signed({7'b0, fmt.frac_bits}) - te;
      neg_sh = -sub_sh;
      if (sub_sh <= 13'sd0) begin
         g_sub = {11'b0, mant} << neg_sh[3:0];
      end else if (sub_sh >= 13'sd54) begin
         g_sub = '0;
      end else begin
         g_sub = round_half_up({11'b0, mant}, sub_sh[5:0]);
      end

      priority if (!fmt.valid) begin
         packed_value = '0;
      end else if (e11 == '1) begin
         packed_value = inf_word;
      end else if ((e11 == '0) && (frac == '0)) begin
         packed_value = sign_word;
      end else if (te >= $signed({2'b0, fmt.exp_max})) begin
         packed_value = inf_word;
      end else if (te >= 13'sd1) begin
         packed_value = sign_word | mag_norm;
      end else begin
         packed_value = sign_word | g_sub;
      end
   end

endmodule

`default_nettype wire

FILE: design/double_to_custom_float.sv
// Converts IEEE binary64 bit patterns into a custom float format chosen at run time.
//
// req_ channel: one double per transfer (req_double_bits), valid/ready handshake.
// rsp_ channel: one packed result per input (rsp_packed_value), right aligned, bits
//   above total_bits are zero. Results come out in input order.
// csr_ channel: index 0 writes total_bits, index 1 writes exp_bits. Always ready.
//   An invalid combination makes every result zero. Write only while idle.
// The input register takes the item at the req_ transfer and the result register
//   takes it from there once that register is free; rsp_valid comes from the result
//   register. Throughput: one item per cycle while the receiver does not stall, with
//   a single conversion pass between the two registers.
// When the receiver stalls, the result register holds its value and the input
//   register still takes one more item; req_ready drops only when both are full.
// Reset clears both valid flags and loads total_bits = 32, exp_bits = 8
//   (single precision).
`default_nettype none

module double_to_custom_float (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [63:0]                   req_double_bits,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [63:0]                   rsp_packed_value,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  dtcf_pkg::csr_index_type       csr_index,
   input  logic [63:0]                   csr_wdata
);
   import dtcf_pkg::*;

   logic [6:0]        total_bits_ff, total_bits_in;
   logic [3:0]        exp_bits_ff, exp_bits_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [63:0]       s1_bits_ff, s1_bits_in;
   logic [LZ_W-1:0]   s1_lz_ff, s1_lz_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [63:0]       rsp_value_ff, rsp_value_in;
   logic [LZ_W-1:0]   lz_now;
   logic [63:0]       conv_value;
   fmt_type           fmt;
   logic              s1_ready;
   logic              s2_ready;

   dtcf_lzc u_lzc (
      .frac       (req_double_bits[51:0]),
      .lead_zeros (lz_now)
   );

   assign fmt = make_fmt(total_bits_ff, exp_bits_ff);

   dtcf_convert u_convert (
      .double_bits  (s1_bits_ff),
      .lead_zeros   (s1_lz_ff),
      .fmt          (fmt),
      .packed_value (conv_value)
   );

   assign s2_ready  = !rsp_valid_ff || rsp_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_packed_value = rsp_value_ff;

   always_comb begin
      total_bits_in = total_bits_ff;
      exp_bits_in   = exp_bits_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TOTAL_BITS: total_bits_in = csr_wdata[6:0];
            CSR_EXP_BITS:   exp_bits_in   = csr_wdata[3:0];
            default:        total_bits_in = total_bits_ff;
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_bits_in   = s1_bits_ff;
      s1_lz_in     = s1_lz_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (s1_ready) begin
         s1_valid_in = req_valid;
         if (req_valid) begin
            s1_bits_in = req_double_bits;
            s1_lz_in   = lz_now;
         end
      end
      if (s2_ready) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            rsp_value_in = conv_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_bits_ff <= TOTAL_BITS_RESET;
         exp_bits_ff   <= EXP_BITS_RESET;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         total_bits_ff <= total_bits_in;
         exp_bits_ff   <= exp_bits_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      s1_bits_ff   <= s1_bits_in;
      s1_lz_ff     <= s1_lz_in;
      rsp_value_ff <= rsp_value_in;
   end

`ifndef SYNTH
   // an accepted transfer always lands in the input register
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted input not held in stage one");

   // a converted item moves into the result register when it is free
   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_ready) |=> rsp_valid_ff)
      else $error("stage one item not passed to result register");

   // a blocked stage one item is kept unchanged
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_ready) |=> (s1_valid_ff && $stable(s1_bits_ff)))
      else $error("stage one item lost while output stalled");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_double_to_custom_float.sv
// self-checking testbench for the double to custom float converter
`default_nettype none

module tb_double_to_custom_float;
   timeunit 1ns;
   timeprecision 1ps;

   import dtcf_pkg::*;

   localparam int IDLE_LIMIT  = 5000;
   localparam int HOLD_CYCLES = 150;
   localparam int MAX_REPORTS = 10;
   localparam int DBL_BIAS    = 1023;
   localparam int DBL_FRAC_W  = 52;
   localparam int DBL_EXP_TOP = 2047;

   typedef struct {
      logic [63:0] double_bits;
      logic [63:0] packed_value;
   } conversion_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [63:0]   req_double_bits = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [63:0]   rsp_packed_value;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_TOTAL_BITS;
   logic [63:0]   csr_wdata = '0;

   // format as the block should currently hold it
   logic [6:0]    fmt_total = TOTAL_BITS_RESET;
   logic [3:0]    fmt_exp   = EXP_BITS_RESET;

   conversion_type awaited_values[$];
   int            failures = 0;
   int            stall_count = 0;
   int            hold_cycles = 0;
   bit            idling = 1'b1;

   double_to_custom_float dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_double_bits  (req_double_bits),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_packed_value (rsp_packed_value),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic logic [63:0] round_half_up(input logic [63:0] v, input int sh);
      return (v >> sh) + ((v >> (sh - 1)) & 64'd1);
   endfunction

   function automatic logic [63:0] narrow_double(input logic [6:0] total,
                                                 input logic [3:0] ebits,
                                                 input logic [63:0] x);
      int          t, e, f, p, e11;
      longint      bias, ue, te, s, exp_max;
      logic [63:0] sign_word, inf_word, frac, fr, m, g, mag;
      t = int'(total);
      e = int'(ebits);
      if (t < 3 || t > 64 || e < 2 || e > 11 || e + 2 > t) return 64'd0;
      f         = t - e - 1;
      sign_word = {63'd0, x[63]} << (t - 1);
      exp_max   = (longint'(1) << e) - 1;
      bias      = (longint'(1) << (e - 1)) - 1;
      inf_word  = sign_word | (64'(exp_max) << f);
      e11       = int'(x[62:52]);
      frac      = {12'd0, x[51:0]};
      if (e11 == DBL_EXP_TOP) return inf_word;
      if (e11 == 0 && frac == 0) return sign_word;
      if (e11 == 0) begin
         // subnormal double: normalise so the leading one sits at the hidden bit
         p = 51;
         while (!frac[p]) p--;
         m  = frac << (DBL_FRAC_W - p);
         ue = longint'(-1022 - (DBL_FRAC_W - p));
      end else begin
         m  = frac | (64'd1 << DBL_FRAC_W);
         ue = longint'(e11 - DBL_BIAS);
      end
      te = ue + bias;
      if (te >= exp_max) return inf_word;
      if (te >= 1) begin
         fr = {12'd0, m[51:0]};
         if (f >= DBL_FRAC_W) g = fr << (f - DBL_FRAC_W);
         else g = round_half_up(fr, DBL_FRAC_W - f);
         // a rounding carry runs on into the exponent field
         mag = (64'(te) << f) + g;
      end else begin
         s = 53 - f - te;
         if (s <= 0) g = m << (-s);
         else if (s >= 54) g = 64'd0;
         else g = round_half_up(m, int'(s));
         mag = g;
      end
      return sign_word | mag;
   endfunction

   // random double weighted towards the range of the current format
   function automatic logic [63:0] pick_double();
      int          t, e, f, bias, ue, e11, drop;
      int unsigned kind;
      logic [63:0] x, mask, half;
      x    = {$urandom, $urandom};
      t    = int'(fmt_total);
      e    = int'(fmt_exp);
      kind = $urandom_range(99);
      if (kind < 8) begin
         case ($urandom_range(2))
            0:       x[62:0]  = '0;
            1:       x[62:0]  = {11'h7ff, 52'd0};
            default: x[62:52] = '1;
         endcase
      end else if (kind < 18) begin
         x[62:52] = '0;
         x[51:0]  = x[51:0] >> $urandom_range(51);
      end else if (kind < 75 && t >= 3 && t <= 64 && e >= 2 && e <= 11 && e + 2 <= t) begin
         f    = t - e - 1;
         bias = (1 << (e - 1)) - 1;
         ue   = int'($urandom_range(2 * bias + f + 6)) - (bias + f + 4);
         e11  = ue + DBL_BIAS;
         if (e11 < 1) e11 = 1;
         if (e11 > DBL_EXP_TOP - 1) e11 = DBL_EXP_TOP - 1;
         x[62:52] = 11'(e11);
         if (f < DBL_FRAC_W) begin
            drop = DBL_FRAC_W - f;
            mask = (64'd1 << drop) - 64'd1;
            half = 64'd1 << (drop - 1);
            case ($urandom_range(4))
               0:       x = (x & ~mask) | half;
               1:       x = (x & ~mask) | (half - 64'd1);
               2:       x[51:0] = '1;
               default: ;
            endcase
         end
      end
      return x;
   endfunction

   task automatic send_double(input logic [63:0] x);
      conversion_type entry;
      if (idling && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_double_bits <= x;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      entry.double_bits  = x;
      entry.packed_value = narrow_double(fmt_total, fmt_exp, x);
      awaited_values.push_back(entry);
   endtask

   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_values.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [63:0] value);
      drain_results(4);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_TOTAL_BITS) fmt_total = value[6:0];
      else fmt_exp = value[3:0];
   endtask

   // upper write data bits are junk and must be ignored
   task automatic set_format(input logic [6:0] total, input logic [3:0] ebits);
      logic [63:0] w;
      w      = {$urandom, $urandom};
      w[6:0] = total;
      write_register(CSR_TOTAL_BITS, w);
      w      = {$urandom, $urandom};
      w[3:0] = ebits;
      write_register(CSR_EXP_BITS, w);
   endtask

   task automatic test_special_values();
      logic [63:0] values[22] = '{
         64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
         64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
         64'h7FF8_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
         64'h3FF0_0000_0000_0000, 64'hBFF8_0000_0000_0000,
         64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
         64'h800F_FFFF_FFFF_FFFF, 64'h47EF_FFFF_E000_0000,
         64'h47EF_FFFF_F000_0000, 64'h3FF0_0000_1000_0000,
         64'h3FF0_0000_0FFF_FFFF, 64'h3FFF_FFFF_F000_0000,
         64'h3810_0000_0000_0000, 64'h380F_FFFF_F000_0000,
         64'h36A0_0000_0000_0000, 64'h3690_0000_0000_0000,
         64'hB680_0000_0000_0000, 64'h3FD5_5555_5555_5555
      };
      foreach (values[i]) send_double(values[i]);
   endtask

   task automatic test_format_extremes();
      logic [6:0] totals[14] = '{7'd4, 7'd64, 7'd64, 7'd13, 7'd5, 7'd16, 7'd24,
                                 7'd3, 7'd64, 7'd65, 7'd12, 7'd32, 7'd0, 7'd127};
      logic [3:0] exps[14]   = '{4'd2, 4'd11, 4'd2, 4'd11, 4'd3, 4'd5, 4'd8,
                                 4'd2, 4'd12, 4'd8, 4'd11, 4'd1, 4'd0, 4'd15};
      foreach (totals[i]) begin
         set_format(totals[i], exps[i]);
         repeat (i < 7 ? 50 : 15) send_double(pick_double());
      end
   endtask

   task automatic test_random_formats();
      int t;
      repeat (13) begin
         if ($urandom_range(5) == 0) begin
            set_format(7'($urandom), 4'($urandom));
         end else begin
            t = $urandom_range(4, 64);
            set_format(7'(t), 4'($urandom_range(2, t - 2 < 11 ? t - 2 : 11)));
         end
         repeat (60) send_double(pick_double());
      end
   endtask

   task automatic test_back_to_back();
      set_format(7'd32, 4'd8);
      idling = 1'b0;
      repeat (150) send_double(pick_double());
      drain_results(4);
      idling = 1'b1;
   endtask

   task automatic test_output_stall();
      set_format(7'd16, 4'd5);
      hold_cycles = HOLD_CYCLES;
      repeat (40) send_double(pick_double());
      drain_results(4);
   endtask

   // result side: random stalls, or one long hold-off when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else begin
            rsp_ready <= !(idling && $urandom_range(99) < 8);
         end
      end
   end

   always @(posedge clock) begin : check_results
      conversion_type head;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_values.size() == 0) begin
            if (failures < MAX_REPORTS)
               $display("unexpected result transfer: packed_value=%h", rsp_packed_value);
            failures++;
         end else begin
            head = awaited_values.pop_front();
            if (rsp_packed_value !== head.packed_value) begin
               if (failures < MAX_REPORTS)
                  $display("mismatch: double=%h packed_value expected %h got %h",
                           head.double_bits, head.packed_value, rsp_packed_value);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         stall_count <= 0;
      end else if (stall_count == IDLE_LIMIT) begin
         $display("tb_double_to_custom_float NOT OK");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_values();
      test_format_extremes();
      test_random_formats();
      test_back_to_back();
      test_output_stall();
      drain_results(10);
      if (failures == 0 && awaited_values.size() == 0) begin
         $display("tb_double_to_custom_float OK");
      end else begin
         $display("tb_double_to_custom_float NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire
